@@ rtl/ddo_pkg.sv @@
// Shared types, angle constants and CORDIC arctangent table for the odometry block.
// No dependencies; used by ddo_cordic and differential_drive_odometry_top.
package ddo_pkg;

  localparam int TRIG_W = 34;
  localparam int CORDIC_STEPS = 30;

  localparam logic signed [TRIG_W-1:0] PI_Q = 34'sd843314857;
  localparam logic signed [TRIG_W-1:0] TWO_PI_Q = 34'sd1686629714;
  localparam logic signed [TRIG_W-1:0] HALF_PI_Q = 34'sd421657428;
  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 34'sh026DD3B6A;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MAG, ST_DL_LO, ST_DL_HI, ST_DR_LO, ST_DR_HI, ST_DR_END,
    ST_DECIDE, ST_ABS, ST_DIV_H, ST_WRAP, ST_RP_LO, ST_RP_HI, ST_RP_ADD,
    ST_DIV_R, ST_COR0_GO, ST_COR0_WAIT, ST_COR1_GO, ST_COR1_WAIT, ST_BUILD,
    ST_MX_LO, ST_MX_HI, ST_MY_LO, ST_MY_HI, ST_MY_END, ST_POS, ST_EMIT
  } ddo_state_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] cos_val;
    logic signed [TRIG_W-1:0] sin_val;
  } ddo_trig_t;

  function automatic logic signed [TRIG_W-1:0] atan_q30(input logic [4:0] idx);
    logic signed [TRIG_W-1:0] v;
    case (idx)
      5'd0: v = 34'sh03243F6A8;
      5'd1: v = 34'sh01DAC6705;
      5'd2: v = 34'sh00FADBAFC;
      5'd3: v = 34'sh007F56EA6;
      5'd4: v = 34'sh003FEAB76;
      5'd5: v = 34'sh001FFD55B;
      5'd6: v = 34'sh000FFFAAA;
      5'd7: v = 34'sh0007FFF55;
      5'd8: v = 34'sh0003FFFEA;
      5'd9: v = 34'sh0001FFFFD;
      5'd10: v = 34'sh0000FFFFF;
      5'd11: v = 34'sh00007FFFF;
      5'd12: v = 34'sh00003FFFF;
      5'd13: v = 34'sh00001FFFF;
      5'd14: v = 34'sh00000FFFF;
      5'd15: v = 34'sh000007FFF;
      5'd16: v = 34'sh000003FFF;
      5'd17: v = 34'sh000001FFF;
      5'd18: v = 34'sh000000FFF;
      5'd19: v = 34'sh0000007FF;
      5'd20: v = 34'sh0000003FF;
      5'd21: v = 34'sh0000001FF;
      5'd22: v = 34'sh0000000FF;
      5'd23: v = 34'sh00000007F;
      5'd24: v = 34'sh00000003F;
      5'd25: v = 34'sh00000001F;
      5'd26: v = 34'sh00000000F;
      5'd27: v = 34'sh000000008;
      5'd28: v = 34'sh000000004;
      5'd29: v = 34'sh000000002;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/ddo_cordic.sv @@
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, Q2.30 sine and cosine.
// Depends on ddo_pkg for the arctangent table, gain and angle constants.
module ddo_cordic (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [31:0]   angle,
  output logic                 done,
  output ddo_pkg::ddo_trig_t   trig
);

  localparam logic [4:0] LAST_STEP = 5'(ddo_pkg::CORDIC_STEPS - 1);

  logic signed [ddo_pkg::TRIG_W-1:0] x, y, z, xs, ys, a_ext, a_red, ang;
  logic [4:0] step;
  logic busy, flip, flip_next;

  always_comb begin
    a_ext = ddo_pkg::TRIG_W'(angle);
    flip_next = 1'b0;
    a_red = a_ext;
    if (a_ext > ddo_pkg::HALF_PI_Q) begin
      a_red = a_ext - ddo_pkg::PI_Q;
      flip_next = 1'b1;
    end else if (a_ext < -ddo_pkg::HALF_PI_Q) begin
      a_red = a_ext + ddo_pkg::PI_Q;
      flip_next = 1'b1;
    end
    xs = x >>> step;
    ys = y >>> step;
    ang = ddo_pkg::atan_q30(step);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && step == LAST_STEP) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= ddo_pkg::CORDIC_GAIN;
      y <= '0;
      z <= a_red <<< 2;
      step <= '0;
      flip <= flip_next;
    end else if (busy) begin
      if (z >= 0) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - ang;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + ang;
      end
      step <= step + 5'd1;
    end
  end

  assign trig.cos_val = flip ? -x : x;
  assign trig.sin_val = flip ? -y : y;

endmodule

@@ rtl/differential_drive_odometry_top.sv @@
// Differential-drive arc odometry: one sample in, one updated pose out.
// Straight moves skip the divides and the second CORDIC pass. For arcs, a 92-step heading
// divide and a 96-step radius divide share one restoring subtractor, two 30-step CORDIC
// passes share ddo_cordic, and all products go through one registered 32x32 multiplier.
// One sample at a time; a finished pose waits in its output register.
// Synchronous reset clears pose, heading, stored counts and restores register defaults.
module differential_drive_odometry_top #(
  parameter int COUNT_WIDTH    = 32,
  parameter int POSITION_WIDTH = 48
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [1:0]                       cfg_index,
  input  logic [31:0]                      cfg_data,
  input  logic                             sample_valid,
  output logic                             sample_stall,
  input  logic signed [COUNT_WIDTH-1:0]    left_count,
  input  logic signed [COUNT_WIDTH-1:0]    right_count,
  output logic                             pose_valid,
  input  logic                             pose_stall,
  output logic signed [POSITION_WIDTH-1:0] pose_x,
  output logic signed [POSITION_WIDTH-1:0] pose_y,
  output logic signed [30:0]               pose_heading
);

  localparam logic [1:0] REG_LEFT_STEP  = 2'd0;
  localparam logic [1:0] REG_RIGHT_STEP = 2'd1;
  localparam logic [1:0] REG_SPACING    = 2'd2;

  localparam logic [63:0] DELTA_LIM = 64'h0000_0020_0000_0000;
  localparam logic [63:0] BIG_LIM   = 64'h4000_0000_0000_0000;
  localparam logic signed [65:0] POS_MAX = (66'sd1 <<< (POSITION_WIDTH - 1)) - 66'sd1;
  localparam logic signed [65:0] POS_MIN = -POS_MAX - 66'sd1;
  localparam logic [6:0] HDIV_LAST = 7'd91;
  localparam logic [6:0] RDIV_LAST = 7'd95;
  localparam logic [31:0] TWO_PI_U = 32'd1686629714;

  ddo_pkg::ddo_state_t state, state_next;

  logic [23:0] left_step, right_step;
  logic [31:0] spacing, sp;
  logic [COUNT_WIDTH-1:0] last_left, last_right, raw_l, raw_r, mfl_l, mfl_r;
  logic [63:0] mext_l, mext_r;
  logic [37:0] mag_l, mag_r;
  logic neg_l, neg_r;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod, wa, wsum;
  logic wneg;
  logic signed [63:0] wsigned, dl, dr, diff, sum, aval, move_dist;
  logic [63:0] diffm, usum, diff_abs, sum_abs;
  logic diff_neg, sum_neg, straight;
  logic [63:0] rem, rem_next, quot, qn, quot_r_next;
  logic [95:0] dvd;
  logic [64:0] rsh, den, rdiff;
  logic ge, sat, qsat, any_q;
  logic [6:0] kcnt;
  logic [31:0] hacc2;
  logic [30:0] hacc_next;
  logic signed [33:0] acc34, hsum, hwr;
  logic signed [31:0] heading, hn, cor_angle;
  logic signed [33:0] c0, s0, c1, s1;
  logic signed [34:0] bx, by, bxa, bya;
  logic [62:0] ua;
  logic [63:0] aabs;
  logic [31:0] ubx, uby;
  logic neg_x, neg_y;
  logic [63:0] plo;
  logic signed [63:0] dx, dy;
  logic signed [POSITION_WIDTH-1:0] pos_x, pos_y;
  logic cor_start, cor_done, pose_load;
  ddo_pkg::ddo_trig_t cor_trig;

  function automatic logic signed [63:0] apply_sign(input logic [63:0] m, input logic neg);
    return neg ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [63:0] q30_scale(input logic [63:0] lo_p,
                                                   input logic [63:0] hi_p,
                                                   input logic neg);
    logic [63:0] r;
    if (hi_p[63:60] != 4'd0) begin
      r = BIG_LIM;
    end else begin
      r = {hi_p[61:0], 2'b00} + (lo_p >> 30);
      if (r > BIG_LIM) r = BIG_LIM;
    end
    return apply_sign(r, neg);
  endfunction

  function automatic logic signed [POSITION_WIDTH-1:0] add_pos(
      input logic signed [POSITION_WIDTH-1:0] p, input logic signed [63:0] d);
    logic signed [65:0] v;
    v = 66'(p) + 66'(d);
    if (v > POS_MAX) v = POS_MAX;
    if (v < POS_MIN) v = POS_MIN;
    return POSITION_WIDTH'(v);
  endfunction

  ddo_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .angle (cor_angle),
    .done  (cor_done),
    .trig  (cor_trig)
  );

  assign cfg_ready = 1'b1;
  assign sp = (spacing == 32'd0) ? 32'd1 : spacing;
  assign pose_load = (state == ddo_pkg::ST_EMIT) && (!pose_valid || !pose_stall);

  always_comb begin
    mfl_l = raw_l[COUNT_WIDTH-1] ? (~raw_l + 1'b1) : raw_l;
    mfl_r = raw_r[COUNT_WIDTH-1] ? (~raw_r + 1'b1) : raw_r;
    mext_l = 64'(mfl_l);
    mext_r = 64'(mfl_r);

    wsum = wa + {prod[31:0], 32'h0};
    wneg = (state == ddo_pkg::ST_DR_LO) ? neg_l : neg_r;
    wsigned = apply_sign(wsum, wneg);

    diff_abs = diff[63] ? 64'(-diff) : 64'(diff);
    sum_abs = sum[63] ? 64'(-sum) : 64'(sum);
    move_dist = (sum + 64'(sum[63])) >>> 1;

    den = (state == ddo_pkg::ST_DIV_H) ? {33'h0, sp} : {1'b0, diffm[62:0], 1'b0};
    rsh = {rem, dvd[95]};
    ge = rsh >= den;
    rdiff = rsh - den;
    rem_next = ge ? rdiff[63:0] : rsh[63:0];

    hacc2 = {quot[30:0], 1'b0} + 32'(ge);
    hacc_next = (hacc2 >= TWO_PI_U) ? 31'(hacc2 - TWO_PI_U) : hacc2[30:0];

    qn = sat ? quot : ({quot[62:0], 1'b0} + 64'(ge));
    qsat = qn > BIG_LIM;
    quot_r_next = qsat ? BIG_LIM : qn;

    acc34 = {3'b000, quot[30:0]};
    hsum = 34'(heading) + (diff_neg ? -acc34 : acc34);
    if (hsum >= ddo_pkg::PI_Q) hwr = hsum - ddo_pkg::TWO_PI_Q;
    else if (hsum < -ddo_pkg::PI_Q) hwr = hsum + ddo_pkg::TWO_PI_Q;
    else hwr = hsum;

    bx = straight ? 35'(c0) : 35'(s1) - 35'(s0);
    by = straight ? 35'(s0) : 35'(c0) - 35'(c1);
    bxa = bx[34] ? -bx : bx;
    bya = by[34] ? -by : by;
    aabs = aval[63] ? 64'(-aval) : 64'(aval);
  end

  always_comb begin
    state_next = state;
    case (state)
      ddo_pkg::ST_IDLE:      if (sample_valid) state_next = ddo_pkg::ST_MAG;
      ddo_pkg::ST_MAG:       state_next = ddo_pkg::ST_DL_LO;
      ddo_pkg::ST_DL_LO:     state_next = ddo_pkg::ST_DL_HI;
      ddo_pkg::ST_DL_HI:     state_next = ddo_pkg::ST_DR_LO;
      ddo_pkg::ST_DR_LO:     state_next = ddo_pkg::ST_DR_HI;
      ddo_pkg::ST_DR_HI:     state_next = ddo_pkg::ST_DR_END;
      ddo_pkg::ST_DR_END:    state_next = ddo_pkg::ST_DECIDE;
      ddo_pkg::ST_DECIDE:    state_next = ddo_pkg::ST_ABS;
      ddo_pkg::ST_ABS: begin
        state_next = straight ? ddo_pkg::ST_COR0_GO : ddo_pkg::ST_DIV_H;
      end
      ddo_pkg::ST_DIV_H: begin
        if (kcnt == 7'd0) begin
          state_next = (any_q || ge) ? ddo_pkg::ST_WRAP : ddo_pkg::ST_COR0_GO;
        end
      end
      ddo_pkg::ST_WRAP:      state_next = ddo_pkg::ST_RP_LO;
      ddo_pkg::ST_RP_LO:     state_next = ddo_pkg::ST_RP_HI;
      ddo_pkg::ST_RP_HI:     state_next = ddo_pkg::ST_RP_ADD;
      ddo_pkg::ST_RP_ADD:    state_next = ddo_pkg::ST_DIV_R;
      ddo_pkg::ST_DIV_R:     if (kcnt == 7'd0) state_next = ddo_pkg::ST_COR0_GO;
      ddo_pkg::ST_COR0_GO:   state_next = ddo_pkg::ST_COR0_WAIT;
      ddo_pkg::ST_COR0_WAIT: begin
        if (cor_done) state_next = straight ? ddo_pkg::ST_BUILD : ddo_pkg::ST_COR1_GO;
      end
      ddo_pkg::ST_COR1_GO:   state_next = ddo_pkg::ST_COR1_WAIT;
      ddo_pkg::ST_COR1_WAIT: if (cor_done) state_next = ddo_pkg::ST_BUILD;
      ddo_pkg::ST_BUILD:     state_next = ddo_pkg::ST_MX_LO;
      ddo_pkg::ST_MX_LO:     state_next = ddo_pkg::ST_MX_HI;
      ddo_pkg::ST_MX_HI:     state_next = ddo_pkg::ST_MY_LO;
      ddo_pkg::ST_MY_LO:     state_next = ddo_pkg::ST_MY_HI;
      ddo_pkg::ST_MY_HI:     state_next = ddo_pkg::ST_MY_END;
      ddo_pkg::ST_MY_END:    state_next = ddo_pkg::ST_POS;
      ddo_pkg::ST_POS:       state_next = ddo_pkg::ST_EMIT;
      ddo_pkg::ST_EMIT:      if (pose_load) state_next = ddo_pkg::ST_IDLE;
      default:               state_next = ddo_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ddo_pkg::ST_DL_LO: begin
        mul_a = mag_l[31:0];
        mul_b = {8'h0, left_step};
      end
      ddo_pkg::ST_DL_HI: begin
        mul_a = {26'h0, mag_l[37:32]};
        mul_b = {8'h0, left_step};
      end
      ddo_pkg::ST_DR_LO: begin
        mul_a = mag_r[31:0];
        mul_b = {8'h0, right_step};
      end
      ddo_pkg::ST_DR_HI: begin
        mul_a = {26'h0, mag_r[37:32]};
        mul_b = {8'h0, right_step};
      end
      ddo_pkg::ST_RP_LO: begin
        mul_a = usum[31:0];
        mul_b = sp;
      end
      ddo_pkg::ST_RP_HI: begin
        mul_a = usum[63:32];
        mul_b = sp;
      end
      ddo_pkg::ST_MX_LO: begin
        mul_a = ua[31:0];
        mul_b = ubx;
      end
      ddo_pkg::ST_MX_HI: begin
        mul_a = {1'b0, ua[62:32]};
        mul_b = ubx;
      end
      ddo_pkg::ST_MY_LO: begin
        mul_a = ua[31:0];
        mul_b = uby;
      end
      ddo_pkg::ST_MY_HI: begin
        mul_a = {1'b0, ua[62:32]};
        mul_b = uby;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    sample_stall = (state != ddo_pkg::ST_IDLE);
    cor_start = (state == ddo_pkg::ST_COR0_GO) || (state == ddo_pkg::ST_COR1_GO);
    cor_angle = (state == ddo_pkg::ST_COR1_GO) ? hn : heading;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ddo_pkg::ST_IDLE;
      left_step <= 24'd65536;
      right_step <= 24'd65536;
      spacing <= 32'd16777216;
      last_left <= '0;
      last_right <= '0;
      pos_x <= '0;
      pos_y <= '0;
      heading <= '0;
      pose_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LEFT_STEP:  left_step <= cfg_data[23:0];
          REG_RIGHT_STEP: right_step <= cfg_data[23:0];
          REG_SPACING:    spacing <= cfg_data;
          default: ;
        endcase
      end
      if (state == ddo_pkg::ST_IDLE && sample_valid) begin
        last_left <= $unsigned(left_count);
        last_right <= $unsigned(right_count);
      end
      if (state == ddo_pkg::ST_POS) begin
        pos_x <= add_pos(pos_x, dx);
        pos_y <= add_pos(pos_y, dy);
        if (!straight) heading <= hn;
      end
      if (pose_load) pose_valid <= 1'b1;
      else if (!pose_stall) pose_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    prod <= 64'(mul_a) * 64'(mul_b);
    case (state)
      ddo_pkg::ST_IDLE: begin
        raw_l <= $unsigned(left_count) - last_left;
        raw_r <= $unsigned(right_count) - last_right;
      end
      ddo_pkg::ST_MAG: begin
        neg_l <= raw_l[COUNT_WIDTH-1];
        neg_r <= raw_r[COUNT_WIDTH-1];
        mag_l <= (mext_l > DELTA_LIM) ? DELTA_LIM[37:0] : mext_l[37:0];
        mag_r <= (mext_r > DELTA_LIM) ? DELTA_LIM[37:0] : mext_r[37:0];
      end
      ddo_pkg::ST_DL_HI:  wa <= prod;
      ddo_pkg::ST_DR_LO:  dl <= wsigned;
      ddo_pkg::ST_DR_HI:  wa <= prod;
      ddo_pkg::ST_DR_END: dr <= wsigned;
      ddo_pkg::ST_DECIDE: begin
        diff <= dr - dl;
        sum <= dl + dr;
        straight <= (dl == dr);
        aval <= dl;
      end
      ddo_pkg::ST_ABS: begin
        diffm <= diff_abs;
        diff_neg <= diff[63];
        usum <= sum_abs;
        sum_neg <= sum[63];
        rem <= '0;
        dvd <= {diff_abs, 32'h0};
        quot <= '0;
        any_q <= 1'b0;
        kcnt <= HDIV_LAST;
      end
      ddo_pkg::ST_DIV_H: begin
        rem <= rem_next;
        dvd <= {dvd[94:0], 1'b0};
        quot <= {33'h0, hacc_next};
        any_q <= any_q | ge;
        kcnt <= kcnt - 7'd1;
        if (kcnt == 7'd0 && !(any_q || ge)) begin
          straight <= 1'b1;
          aval <= move_dist;
        end
      end
      ddo_pkg::ST_WRAP:  hn <= hwr[31:0];
      ddo_pkg::ST_RP_HI: dvd <= {32'h0, prod};
      ddo_pkg::ST_RP_ADD: begin
        dvd <= dvd + {prod, 32'h0};
        rem <= '0;
        quot <= '0;
        sat <= 1'b0;
        kcnt <= RDIV_LAST;
      end
      ddo_pkg::ST_DIV_R: begin
        rem <= rem_next;
        dvd <= {dvd[94:0], 1'b0};
        quot <= quot_r_next;
        sat <= sat | qsat;
        kcnt <= kcnt - 7'd1;
        if (kcnt == 7'd0) aval <= apply_sign(quot_r_next, sum_neg ^ diff_neg);
      end
      ddo_pkg::ST_COR0_WAIT: begin
        if (cor_done) begin
          c0 <= cor_trig.cos_val;
          s0 <= cor_trig.sin_val;
        end
      end
      ddo_pkg::ST_COR1_WAIT: begin
        if (cor_done) begin
          c1 <= cor_trig.cos_val;
          s1 <= cor_trig.sin_val;
        end
      end
      ddo_pkg::ST_BUILD: begin
        ua <= aabs[62:0];
        ubx <= (bxa[34:32] != 3'd0) ? 32'hFFFF_FFFF : bxa[31:0];
        uby <= (bya[34:32] != 3'd0) ? 32'hFFFF_FFFF : bya[31:0];
        neg_x <= aval[63] ^ bx[34];
        neg_y <= aval[63] ^ by[34];
      end
      ddo_pkg::ST_MX_HI:  plo <= prod;
      ddo_pkg::ST_MY_LO:  dx <= q30_scale(plo, prod, neg_x);
      ddo_pkg::ST_MY_HI:  plo <= prod;
      ddo_pkg::ST_MY_END: dy <= q30_scale(plo, prod, neg_y);
      default: ;
    endcase
    if (pose_load) begin
      pose_x <= pos_x;
      pose_y <= pos_y;
      pose_heading <= heading[30:0];
    end
  end

endmodule

@@ rtl/ddo_checker.sv @@
// Port-level assertions for differential_drive_odometry_top.
// Attached to the top level by the bind statement at the end of this file.
module ddo_checker #(
  parameter int POSITION_WIDTH = 48
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             sample_valid,
  input logic                             sample_stall,
  input logic                             pose_valid,
  input logic                             pose_stall,
  input logic signed [POSITION_WIDTH-1:0] pose_x,
  input logic signed [POSITION_WIDTH-1:0] pose_y,
  input logic signed [30:0]               pose_heading
);

  a_pose_hold: assert property (@(posedge clk) disable iff (rst)
    pose_valid && pose_stall |=> pose_valid)
    else $error("pose transfer dropped while stalled");

  a_pose_stable: assert property (@(posedge clk) disable iff (rst)
    pose_valid && pose_stall |=> $stable(pose_x) && $stable(pose_y) && $stable(pose_heading))
    else $error("pose payload changed while stalled");

  a_busy_after_sample: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall |=> sample_stall)
    else $error("sample taken without going busy");

  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    pose_valid |-> (pose_heading >= -31'sd843314857) && (pose_heading < 31'sd843314857))
    else $error("heading outside the half-open pi range");

endmodule

bind differential_drive_odometry_top ddo_checker #(.POSITION_WIDTH(POSITION_WIDTH)) u_ddo_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_stall (sample_stall),
  .pose_valid   (pose_valid),
  .pose_stall   (pose_stall),
  .pose_x       (pose_x),
  .pose_y       (pose_y),
  .pose_heading (pose_heading)
);
